// File: rtl/lia_pkg.sv
// shared widths, constants and arctangent table of the linkage incline angle core
package lia_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ROUND_SHIFT     = 16 - ANGLE_FRAC_BITS;
  localparam int CORDIC_STEPS    = 20;

  localparam int LEN_W   = 14;
  localparam int OFS_W   = 16;
  localparam int HOR_W   = 17;
  localparam int C2_W    = 33;
  localparam int NOM_W   = 35;
  localparam int C8_W    = 25;
  localparam int DEN_W   = 40;
  localparam int MAG8_W  = 43;
  localparam int U_W     = 17;
  localparam int ACOS_W  = 30;
  localparam int ATAN_W  = 40;
  localparam int Z_W     = 24;
  localparam int TH_W    = 27;
  localparam int ANGLE_W = 18;

  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945, 24'sd234379,
    24'sd117304,  24'sd58666,   24'sd29335,  24'sd14668,  24'sd7334,
    24'sd3667,    24'sd1833,    24'sd917,    24'sd458,    24'sd229,
    24'sd115,     24'sd57,      24'sd29,     24'sd14,     24'sd7
  };

endpackage

// File: rtl/lia_isqrt.sv
// pipelined integer square root, one result bit per stage
module lia_isqrt
  import lia_pkg::*;
#(
  parameter int RW  = 17,
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*RW-1:0]   n,
  input  logic [SBW-1:0]    sb_in,
  output logic [RW-1:0]     root,
  output logic [SBW-1:0]    sb_out
);

  logic [2*RW-1:0] n_q    [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SBW-1:0]  sb_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [2*RW-1:0] n_i;
    logic [RW+1:0]   rem_i;
    logic [RW-1:0]   root_i;
    logic [SBW-1:0]  sb_i;
    logic [RW+3:0]   rem_w;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   rem_s;
    logic            ge;

    if (k == 0) begin : g_first
      assign n_i    = n;
      assign rem_i  = '0;
      assign root_i = '0;
      assign sb_i   = sb_in;
    end else begin : g_next
      assign n_i    = n_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign sb_i   = sb_q[k-1];
    end

    always_comb begin
      rem_w = {rem_i, n_i[2*RW-1 -: 2]};
      trial = {2'b00, root_i, 2'b01};
      ge    = (rem_w >= trial);
      rem_s = ge ? (rem_w - trial) : rem_w;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k]    <= {n_i[2*RW-3:0], 2'b00};
        rem_q[k]  <= rem_s[RW+1:0];
        root_q[k] <= {root_i[RW-2:0], ge};
        sb_q[k]   <= sb_i;
      end
    end
  end

  assign root   = root_q[RW-1];
  assign sb_out = sb_q[RW-1];

endmodule

// File: rtl/lia_cordic.sv
// pipelined cordic vectoring, one rotation per stage, angle in 1/65536 degree
module lia_cordic
  import lia_pkg::*;
#(
  parameter int XW  = 30,
  parameter int SBW = 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [XW-1:0]  x,
  input  logic signed [XW-1:0]  y,
  input  logic [SBW-1:0]        sb_in,
  output logic signed [Z_W-1:0] z,
  output logic [SBW-1:0]        sb_out
);

  logic signed [XW-1:0]  x_q  [CORDIC_STEPS];
  logic signed [XW-1:0]  y_q  [CORDIC_STEPS];
  logic signed [Z_W-1:0] z_q  [CORDIC_STEPS];
  logic [SBW-1:0]        sb_q [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_st
    logic signed [XW-1:0]  x_i;
    logic signed [XW-1:0]  y_i;
    logic signed [Z_W-1:0] z_i;
    logic [SBW-1:0]        sb_i;
    logic signed [XW-1:0]  yabs;
    logic signed [XW-1:0]  dx;
    logic signed [XW-1:0]  dy;

    if (k == 0) begin : g_first
      assign x_i  = x;
      assign y_i  = y;
      assign z_i  = '0;
      assign sb_i = sb_in;
    end else begin : g_next
      assign x_i  = x_q[k-1];
      assign y_i  = y_q[k-1];
      assign z_i  = z_q[k-1];
      assign sb_i = sb_q[k-1];
    end

    // shifts round toward zero
    always_comb begin
      yabs = -y_i;
      dy   = x_i >>> k;
      dx   = y_i[XW-1] ? -(yabs >>> k) : (y_i >>> k);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_q[k] <= sb_i;
        if (y_i == '0) begin
          x_q[k] <= x_i;
          y_q[k] <= y_i;
          z_q[k] <= z_i;
        end else if (!y_i[XW-1]) begin
          x_q[k] <= x_i + dx;
          y_q[k] <= y_i - dy;
          z_q[k] <= z_i + ATAN_TAB[k];
        end else begin
          x_q[k] <= x_i - dx;
          y_q[k] <= y_i + dy;
          z_q[k] <= z_i - ATAN_TAB[k];
        end
      end
    end
  end

  assign z      = z_q[CORDIC_STEPS-1];
  assign sb_out = sb_q[CORDIC_STEPS-1];

endmodule

// File: rtl/linkage_incline_angle_core.sv
// top level: pedal incline angle of a three-pivot linkage from one sled position
// Takes one sled position per cycle and returns the incline angle in 1/256 degree plus an
// out-of-reach flag; fully pipelined (four squaring and sum stages, a 25-stage square root
// for the pivot distance, two stages for the denominator and the clamp, a 17-stage divider
// for the cosine, two stages for one minus the squared cosine, a 17-stage square root for
// the sine, one stage for the launch vectors, two 20-stage cordic units running side by
// side, and two stages for the sum, rounding and the saturated output register). The whole
// pipeline holds while a result waits at the output; the user must write lengths over the
// config channel only while no item is in flight, which the block does not enforce.
module linkage_incline_angle_core
  import lia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sled_position
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [17:0] incline_angle, [23:18] zero
  output logic        m_tuser    // [0] out_of_reach
);

  localparam logic [1:0] REG_PEDAL_ARM  = 2'd0;
  localparam logic [1:0] REG_BASE_ARM   = 2'd1;
  localparam logic [1:0] REG_VERT_OFS   = 2'd2;
  localparam logic [1:0] REG_HORIZ_OFS  = 2'd3;

  localparam int LAT = 4 + C8_W + 2 + U_W + 2 + U_W + 1 + CORDIC_STEPS + 2;

  localparam logic signed [TH_W-1:0] HALF_PI2  = TH_W'(180 * 65536);
  localparam logic signed [TH_W-1:0] RND_HALF  = TH_W'(2 ** (ROUND_SHIFT - 1));
  localparam logic signed [TH_W-1:0] SAT_LO    = TH_W'(-90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [TH_W-1:0] SAT_HI    = TH_W'(270 * (2 ** ANGLE_FRAC_BITS));

  localparam int SB1_W = NOM_W + HOR_W;
  localparam int DSB_W = 3 + HOR_W;
  localparam int SB2_W = U_W + 3 + HOR_W;

  // config registers
  logic [LEN_W-1:0]        pedal_arm_length;
  logic [LEN_W-1:0]        base_arm_length;
  logic signed [OFS_W-1:0] vertical_offset;
  logic signed [OFS_W-1:0] horizontal_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_arm_length  <= '0;
      base_arm_length   <= '0;
      vertical_offset   <= '0;
      horizontal_offset <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PEDAL_ARM:  pedal_arm_length  <= cfg_data[LEN_W-1:0];
        REG_BASE_ARM:   base_arm_length   <= cfg_data[LEN_W-1:0];
        REG_VERT_OFS:   vertical_offset   <= cfg_data;
        REG_HORIZ_OFS:  horizontal_offset <= cfg_data;
      endcase
    end
  end

  // pipeline control
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // stage 1: horizontal offset
  logic signed [HOR_W-1:0] hor1;

  always_ff @(posedge clk) begin
    if (adv) begin
      hor1 <= {horizontal_offset[OFS_W-1], horizontal_offset} + {s_tdata[15], s_tdata};
    end
  end

  // stage 2: squares
  logic signed [2*HOR_W-1:0] hor_sq;
  logic signed [2*OFS_W-1:0] ver_sq;
  logic [C2_W-1:0]           hor2;
  logic [C2_W-2:0]           ver2;
  logic [2*LEN_W-1:0]        a2;
  logic [2*LEN_W-1:0]        b2;
  logic signed [HOR_W-1:0]   hor2p;

  assign hor_sq = hor1 * hor1;
  assign ver_sq = vertical_offset * vertical_offset;

  always_ff @(posedge clk) begin
    if (adv) begin
      hor2  <= hor_sq[C2_W-1:0];
      ver2  <= ver_sq[C2_W-2:0];
      a2    <= pedal_arm_length * pedal_arm_length;
      b2    <= base_arm_length * base_arm_length;
      hor2p <= hor1;
    end
  end

  // stage 3: distance squared and arm difference
  logic [C2_W-1:0]            c2_3;
  logic signed [2*LEN_W:0]    dab3;
  logic signed [HOR_W-1:0]    hor3;

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_3 <= hor2 + {1'b0, ver2};
      dab3 <= $signed({1'b0, b2}) - $signed({1'b0, a2});
      hor3 <= hor2p;
    end
  end

  // stage 4: cosine numerator
  logic [C2_W-1:0]          c2_4;
  logic signed [NOM_W-1:0]  nom4;
  logic signed [HOR_W-1:0]  hor4;

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_4 <= c2_3;
      nom4 <= $signed({2'b00, c2_3}) + {{(NOM_W-2*LEN_W-1){dab3[2*LEN_W]}}, dab3};
      hor4 <= hor3;
    end
  end

  // pivot distance with 8 fraction bits
  logic [C8_W-1:0]  c8;
  logic [SB1_W-1:0] sb1;

  lia_isqrt #(
    .RW  (C8_W),
    .SBW (SB1_W)
  ) u_dist_sqrt (
    .clk    (clk),
    .en     (adv),
    .n      ({1'b0, c2_4, 16'h0000}),
    .sb_in  ({nom4, hor4}),
    .root   (c8),
    .sb_out (sb1)
  );

  // stage d: denominator and numerator magnitude
  logic signed [NOM_W-1:0] nom_d;
  logic [NOM_W-1:0]        mag_d;
  logic [DEN_W-2:0]        bc_d;
  logic [DEN_W-1:0]        den_d;
  logic [MAG8_W-1:0]       mag8_d;
  logic                    neg_d;
  logic signed [HOR_W-1:0] hor_d;

  assign nom_d = sb1[SB1_W-1 -: NOM_W];
  assign mag_d = nom_d[NOM_W-1] ? NOM_W'(-nom_d) : NOM_W'(nom_d);
  assign bc_d  = base_arm_length * c8;

  always_ff @(posedge clk) begin
    if (adv) begin
      den_d  <= {bc_d, 1'b0};
      mag8_d <= {mag_d, 8'h00};
      neg_d  <= nom_d[NOM_W-1];
      hor_d  <= sb1[HOR_W-1:0];
    end
  end

  // stage e: clamp and special cases
  logic [DEN_W:0]   r_e;
  logic [DEN_W-1:0] den_e;
  logic [DSB_W-1:0] sb_e;
  logic             over_d;
  logic             dz_d;

  assign over_d = mag8_d > {3'b000, den_d};
  assign dz_d   = den_d == '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_e   <= {1'b0, over_d ? den_d : mag8_d[DEN_W-1:0]};
      den_e <= den_d;
      sb_e  <= {neg_d, over_d && !dz_d, dz_d, hor_d};
    end
  end

  // cosine magnitude divider, one quotient bit per stage
  logic [DEN_W:0]   dv_r   [U_W];
  logic [U_W-1:0]   dv_q   [U_W];
  logic [DEN_W-1:0] dv_d   [U_W];
  logic [DSB_W-1:0] dv_sb  [U_W];

  for (genvar k = 0; k < U_W; k++) begin : g_div
    logic [DEN_W:0]   r_i;
    logic [U_W-1:0]   q_i;
    logic [DEN_W-1:0] d_i;
    logic [DSB_W-1:0] sb_i;
    logic             ge;
    logic [DEN_W:0]   r_s;

    if (k == 0) begin : g_first
      assign r_i  = r_e;
      assign q_i  = '0;
      assign d_i  = den_e;
      assign sb_i = sb_e;
    end else begin : g_next
      assign r_i  = dv_r[k-1];
      assign q_i  = dv_q[k-1];
      assign d_i  = dv_d[k-1];
      assign sb_i = dv_sb[k-1];
    end

    always_comb begin
      ge  = r_i >= {1'b0, d_i};
      r_s = ge ? (r_i - {1'b0, d_i}) : r_i;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k]  <= {r_s[DEN_W-1:0], 1'b0};
        dv_q[k]  <= {q_i[U_W-2:0], ge};
        dv_d[k]  <= d_i;
        dv_sb[k] <= sb_i;
      end
    end
  end

  // stage f: cosine squared
  logic [U_W-1:0]   u_f;
  logic [2*U_W-1:0] u2_f;
  logic [DSB_W-1:0] sb_f;

  always_ff @(posedge clk) begin
    if (adv) begin
      u_f  <= dv_q[U_W-1];
      u2_f <= dv_q[U_W-1] * dv_q[U_W-1];
      sb_f <= dv_sb[U_W-1];
    end
  end

  // stage g: one minus cosine squared
  logic [2*U_W-1:0] arg_g;
  logic [SB2_W-1:0] sb_g;

  always_ff @(posedge clk) begin
    if (adv) begin
      arg_g <= (2*U_W)'(64'h1_0000_0000) - u2_f;
      sb_g  <= {u_f, sb_f};
    end
  end

  // sine
  logic [U_W-1:0]   s_s;
  logic [SB2_W-1:0] sb_s;

  lia_isqrt #(
    .RW  (U_W),
    .SBW (SB2_W)
  ) u_sin_sqrt (
    .clk    (clk),
    .en     (adv),
    .n      (arg_g),
    .sb_in  (sb_g),
    .root   (s_s),
    .sb_out (sb_s)
  );

  // stage h: cordic launch vectors
  logic [U_W-1:0]            u_s;
  logic signed [HOR_W-1:0]   hor_s;
  logic [HOR_W-1:0]          hx_s;
  logic signed [HOR_W-1:0]   ver_x;
  logic signed [HOR_W-1:0]   vy_s;
  logic signed [ACOS_W-1:0]  ax_h;
  logic signed [ACOS_W-1:0]  ay_h;
  logic signed [ATAN_W-1:0]  bx_h;
  logic signed [ATAN_W-1:0]  by_h;
  logic [2:0]                fl_h;
  logic                      hz_h;

  assign u_s   = sb_s[SB2_W-1 -: U_W];
  assign hor_s = sb_s[HOR_W-1:0];
  assign hx_s  = hor_s[HOR_W-1] ? HOR_W'(-hor_s) : HOR_W'(hor_s);
  assign ver_x = {vertical_offset[OFS_W-1], vertical_offset};
  assign vy_s  = hor_s[HOR_W-1] ? -ver_x : ver_x;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_h <= {3'b000, u_s, 10'h000};
      ay_h <= {3'b000, s_s, 10'h000};
      bx_h <= {3'b000, hx_s, 20'h00000};
      by_h <= {{3{vy_s[HOR_W-1]}}, vy_s, 20'h00000};
      fl_h <= sb_s[HOR_W+2:HOR_W];
      hz_h <= hor_s == '0;
    end
  end

  // arc cosine and arc tangent
  logic signed [Z_W-1:0] za;
  logic signed [Z_W-1:0] zb;
  logic [2:0]            fl_c;
  logic                  hz_c;

  lia_cordic #(
    .XW  (ACOS_W),
    .SBW (3)
  ) u_acos (
    .clk    (clk),
    .en     (adv),
    .x      (ax_h),
    .y      (ay_h),
    .sb_in  (fl_h),
    .z      (za),
    .sb_out (fl_c)
  );

  lia_cordic #(
    .XW  (ATAN_W),
    .SBW (1)
  ) u_atan (
    .clk    (clk),
    .en     (adv),
    .x      (bx_h),
    .y      (by_h),
    .sb_in  (hz_h),
    .z      (zb),
    .sb_out (hz_c)
  );

  // stage i: angle sum in 1/65536 degree
  logic signed [TH_W-1:0] za_x;
  logic signed [TH_W-1:0] zb_x;
  logic signed [TH_W-1:0] acos_t;
  logic signed [TH_W-1:0] theta_i;
  logic                   over_i;

  assign za_x   = {{(TH_W-Z_W){za[Z_W-1]}}, za};
  assign zb_x   = hz_c ? '0 : {{(TH_W-Z_W){zb[Z_W-1]}}, zb};
  assign acos_t = fl_c[0] ? '0 : (fl_c[2] ? (HALF_PI2 - za_x) : za_x);

  always_ff @(posedge clk) begin
    if (adv) begin
      theta_i <= acos_t + zb_x;
      over_i  <= fl_c[1];
    end
  end

  // stage j: round, saturate, output register
  logic signed [TH_W-1:0] rnd;
  logic signed [TH_W-1:0] sat;

  always_comb begin
    rnd = (theta_i + RND_HALF) >>> ROUND_SHIFT;
    priority if (rnd < SAT_LO) begin
      sat = SAT_LO;
    end else if (rnd > SAT_HI) begin
      sat = SAT_HI;
    end else begin
      sat = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {6'b000000, sat[ANGLE_W-1:0]};
      m_tuser <= over_i;
    end
  end

endmodule

// File: tb/sv/tb.sv
// testbench for the linkage incline angle core: directed table and random positions
module tb;
  import lia_pkg::*;

  localparam int LATENCY = 90;
  localparam int N_RAND  = 830;
  localparam longint LIMIT = 2000000;

  typedef enum logic [1:0] {
    REG_PEDAL = 2'd0, REG_BASE = 2'd1, REG_VER = 2'd2, REG_HOR = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [17:0] angle;
    logic        reach;
  } angle_t;

  typedef struct {
    logic [15:0] pos;
    bit          known;
    angle_t      res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  logic [13:0] arm_a, arm_b;
  logic [15:0] ofs_v, ofs_h;
  angle_t      angle_q[$];
  int          n_fail = 0;
  int          n_items = 0;
  int          n_reach = 0;
  longint      cycles = 0;

  linkage_incline_angle_core u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint shr_tz(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y == 0) break;
      dx = shr_tz(y, i);
      dy = shr_tz(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic angle_t incline_of(logic [15:0] pos);
    longint a, b, ver, hor, nom8, theta, res, mag, u, s, ang;
    longint unsigned c2, c8, den8, t;
    angle_t r;
    a = arm_a; b = arm_b;
    ver = $signed(ofs_v);
    hor = longint'($signed(ofs_h)) + longint'($signed(pos));
    c2 = ver * ver + hor * hor;
    c8 = int_sqrt(c2 << 16);
    nom8 = (b * b + longint'(c2) - a * a) * 256;
    den8 = 2 * b * c8;
    theta = 0;
    r.reach = 1'b0;
    if (den8 != 0) begin
      mag = nom8 < 0 ? -nom8 : nom8;
      if (longint'(mag) > longint'(den8)) begin
        r.reach = 1'b1;
        u = 65536;
      end else begin
        u = (longint'(mag) << 16) / den8;
      end
      s = int_sqrt((64'd1 << 32) - u * u);
      ang = vector_angle(u * 1024, s * 1024);
      theta = nom8 < 0 ? 180 * 65536 - ang : ang;
    end
    if (hor != 0)
      theta += vector_angle((hor < 0 ? -hor : hor) * 1048576,
                            (hor < 0 ? -ver : ver) * 1048576);
    t = theta + (64'd1 << 30);
    t = (t + ((64'd1 << ROUND_SHIFT) >> 1)) >> ROUND_SHIFT;
    res = longint'(t) - longint'((64'd1 << 30) >> ROUND_SHIFT);
    if (res < -90 * (1 << ANGLE_FRAC_BITS)) res = -90 * (1 << ANGLE_FRAC_BITS);
    if (res > 270 * (1 << ANGLE_FRAC_BITS)) res = 270 * (1 << ANGLE_FRAC_BITS);
    r.angle = res[17:0];
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      REG_PEDAL: arm_a = val[13:0];
      REG_BASE:  arm_b = val[13:0];
      REG_VER:   ofs_v = val;
      REG_HOR:   ofs_h = val;
    endcase
  endtask

  task automatic set_linkage(logic [13:0] a, logic [13:0] b, logic [15:0] v, logic [15:0] h);
    write_reg(REG_PEDAL, {2'b0, a});
    write_reg(REG_BASE, {2'b0, b});
    write_reg(REG_VER, v);
    write_reg(REG_HOR, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (angle_q.size() != 0) @(posedge clk);
    idle_cycles(LATENCY + 10);
  endtask

  // random idle gap per item, with stretches of back to back traffic
  function automatic int gap_draw(bit busy);
    if (busy) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic send_pos(logic [15:0] pos, bit known, angle_t want, int gap);
    angle_t p;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      idle_cycles(gap);
    end
    p = incline_of(pos);
    if (known && p != want) begin
      $error("table row mismatch pos=%0d want=%h pred=%h", $signed(pos), want, p);
      n_fail++;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pos;
    do @(posedge clk); while (!s_tready);
    angle_q.push_back(p);
    n_items++;
    n_reach += p.reach;
  endtask

  task automatic stop_sending;
    s_tvalid <= 1'b0;
  endtask

  // result side
  initial begin : sink
    int gap;
    bit busy;
    forever begin
      busy = ($urandom_range(0, 3) == 0);
      gap = gap_draw(busy);
      if (gap > 0) begin
        m_tready <= 1'b0;
        idle_cycles(gap);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (angle_q.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        n_fail++;
      end else begin
        angle_t w;
        w = angle_q.pop_front();
        if (m_tdata[17:0] !== w.angle) begin
          $error("incline_angle expected %0d got %0d", $signed(w.angle),
                 $signed(m_tdata[17:0]));
          n_fail++;
        end
        if (m_tdata[23:18] !== 6'd0) begin
          $error("pad expected 0 got %h", m_tdata[23:18]);
          n_fail++;
        end
        if (m_tuser !== w.reach) begin
          $error("out_of_reach expected %0b got %0b", w.reach, m_tuser);
          n_fail++;
        end
      end
    end
  end

  row_t table_rows[$];

  initial begin : stim
    angle_t none;
    bit busy;
    none = '0;
    arm_a = '0; arm_b = '0; ofs_v = '0; ofs_h = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset all lengths zero: hor zero gives 0, hor>0 with ver 0 gives 0
    table_rows.push_back('{16'h0000, 1'b1, '{18'd0, 1'b0}});
    table_rows.push_back('{16'h7FFF, 1'b1, '{18'd0, 1'b0}});
    table_rows.push_back('{16'h8000, 1'b0, none});
    foreach (table_rows[i])
      send_pos(table_rows[i].pos, table_rows[i].known, table_rows[i].res, $urandom_range(0, 3));
    stop_sending;
    drain;

    // extremes: vertical only, out of reach, zero base
    set_linkage(14'h3FFF, 14'h3FFF, 16'h7FFF, 16'h8000);
    send_pos(16'h8000, 1'b0, none, 0);
    send_pos(16'h7FFF, 1'b0, none, 0);
    send_pos(16'h0000, 1'b0, none, 1);
    send_pos(16'hFFFF, 1'b0, none, 0);
    send_pos(16'h0001, 1'b0, none, 2);
    stop_sending;
    drain;
    set_linkage(14'd0, 14'd0, 16'h8000, 16'h7FFF);
    send_pos(16'h8001, 1'b0, none, 0);
    send_pos(16'h7FFF, 1'b0, none, 0);
    send_pos(16'h0000, 1'b0, none, 0);
    send_pos(16'h8000, 1'b0, none, 0);
    stop_sending;
    drain;
    // reach limit: a huge vs tiny b
    set_linkage(14'h3FFF, 14'd1, 16'd0, 16'd100);
    send_pos(16'd0, 1'b0, none, 0);
    send_pos(16'hFF9C, 1'b0, none, 0);
    send_pos(16'h5555, 1'b0, none, 0);
    send_pos(16'hAAAA, 1'b0, none, 0);
    stop_sending;
    drain;

    // random phases of realistic geometry plus occasional wild settings
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2)
        set_linkage(14'($urandom), 14'($urandom), 16'($urandom), 16'($urandom));
      else
        set_linkage(14'($urandom_range(1000, 4000)), 14'($urandom_range(1000, 4000)),
                    16'($urandom_range(0, 4000) - 2000),
                    16'($urandom_range(0, 5000) - 500));
      busy = 1'b0;
      for (int k = 0; k < N_RAND / 10; k++) begin
        logic [15:0] pos;
        if ($urandom_range(0, 20) == 0) busy = !busy;
        case ($urandom_range(0, 5))
          0: pos = 16'($urandom);
          1: pos = -ofs_h;
          default: pos = 16'($urandom_range(0, 4000) - 2000);
        endcase
        send_pos(pos, 1'b0, none, gap_draw(busy));
      end
      stop_sending;
      drain;
    end

    $display("%0d positions sent over 14 linkage settings, %0d clamped as out of reach",
             n_items, n_reach);
    if (n_fail == 0 && angle_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lia_pkg.sv
rtl/lia_isqrt.sv
rtl/lia_cordic.sv
rtl/linkage_incline_angle_core.sv
tb/sv/tb.sv
